// ===== design/lvfr_pkg.sv =====
// ----------------------------------------------------------------------------
// lvfr_pkg
// Shared constants and controller/datapath interface types for the volume
// fade generator.
// ----------------------------------------------------------------------------
package lvfr_pkg;

   localparam int FRAC_BITS  = 24;
   localparam int PORT_FRAC  = 16;
   localparam int PORT_SHIFT = FRAC_BITS - PORT_FRAC;
   localparam int PORT_W     = 20;
   localparam int LEVEL_W    = 4 + FRAC_BITS;
   localparam int STEP_W     = LEVEL_W + 1;
   localparam int MS_W       = 16;
   localparam int PROD_W     = STEP_W + MS_W + 1;
   localparam int NL_W       = PROD_W + 1;
   localparam int CNT_W      = $clog2(LEVEL_W + 1);

   localparam logic KIND_SET  = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch the accepted word, set up the divider
      logic div_step;  // one restoring divide step
      logic mul;       // register step * elapsed
      logic commit;    // update level/goal/step and the result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_tick;
      logic fade_zero;
      logic active;    // level != goal and step != 0
      logic div_last;
   } status_type;

endpackage

// ===== design/lvfr_dpath.sv =====
// ----------------------------------------------------------------------------
// lvfr_dpath
// Level, goal and step registers, serial step divider and the tick
// multiply-accumulate with clamp.
// ----------------------------------------------------------------------------
module lvfr_dpath (
   input  logic                      clock,
   input  logic                      reset,
   input  lvfr_pkg::cmd_type         cmd,
   output lvfr_pkg::status_type      status,
   input  logic                      req_kind,
   input  logic [lvfr_pkg::PORT_W-1:0] req_target_level,
   input  logic [lvfr_pkg::MS_W-1:0] req_fade_ms,
   input  logic [lvfr_pkg::MS_W-1:0] req_elapsed_ms,
   output logic [lvfr_pkg::PORT_W-1:0] level_out,
   output logic                      applied,
   output logic                      ramping
);
   import lvfr_pkg::*;

   logic                       kind_ff;
   logic [LEVEL_W-1:0]         tgt_ff;
   logic [MS_W-1:0]            fade_ff;
   logic [MS_W-1:0]            el_ff;
   logic                       neg_ff;
   logic                       diff_nz_ff;
   logic [LEVEL_W-1:0]         dq_ff;
   logic [MS_W-1:0]            rem_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic [LEVEL_W-1:0]         level_ff, level_in;
   logic [LEVEL_W-1:0]         goal_ff, goal_in;
   logic signed [STEP_W-1:0]   step_ff, step_in;
   logic                       applied_ff, applied_in;

   logic [LEVEL_W-1:0]         tgt_new;
   logic signed [STEP_W-1:0]   diff;
   logic [LEVEL_W-1:0]         diff_mag;
   logic [MS_W:0]              trial;
   logic                       trial_ge;
   logic [LEVEL_W-1:0]         q_mag;
   logic signed [NL_W-1:0]     nl;
   logic signed [NL_W-1:0]     goal_ext;
   logic                       reach;
   logic                       active;

   assign tgt_new  = LEVEL_W'(req_target_level) << PORT_SHIFT;
   assign diff     = $signed({1'b0, tgt_new}) - $signed({1'b0, level_ff});
   assign diff_mag = diff[STEP_W-1] ? LEVEL_W'(-diff) : LEVEL_W'(diff);

   assign trial    = {rem_ff, dq_ff[LEVEL_W-1]};
   assign trial_ge = trial >= {1'b0, fade_ff};

   // truncated quotient; force one LSB so a tiny difference still ramps
   assign q_mag = (dq_ff == '0 && diff_nz_ff) ? LEVEL_W'(1) : dq_ff;

   assign nl       = NL_W'($signed({1'b0, level_ff})) + NL_W'(prod_ff);
   assign goal_ext = NL_W'($signed({1'b0, goal_ff}));
   assign reach    = step_ff[STEP_W-1] ? (nl <= goal_ext) : (nl >= goal_ext);

   assign active = (level_ff != goal_ff) && (step_ff != '0);

   always_comb begin
      level_in   = level_ff;
      goal_in    = goal_ff;
      step_in    = step_ff;
      applied_in = applied_ff;
      if (cmd.commit) begin
         if (kind_ff == KIND_SET) begin
            goal_in = tgt_ff;
            if (fade_ff == '0) begin
               level_in   = tgt_ff;
               step_in    = '0;
               applied_in = 1'b1;
            end else begin
               step_in    = neg_ff ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
               applied_in = 1'b0;
            end
         end else if (!active) begin
            applied_in = 1'b0;
         end else begin
            applied_in = 1'b1;
            if (reach) begin
               level_in = goal_ff;
               step_in  = '0;
            end else begin
               level_in = nl[LEVEL_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff   <= '0;
         goal_ff    <= '0;
         step_ff    <= '0;
         applied_ff <= 1'b0;
      end else begin
         level_ff   <= level_in;
         goal_ff    <= goal_in;
         step_ff    <= step_in;
         applied_ff <= applied_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff    <= req_kind;
         tgt_ff     <= tgt_new;
         fade_ff    <= req_fade_ms;
         el_ff      <= req_elapsed_ms;
         neg_ff     <= diff[STEP_W-1];
         diff_nz_ff <= diff != '0;
         dq_ff      <= diff_mag;
         rem_ff     <= '0;
         cnt_ff     <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= trial_ge ? MS_W'(trial - {1'b0, fade_ff}) : MS_W'(trial);
         dq_ff  <= {dq_ff[LEVEL_W-2:0], trial_ge};
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
      if (cmd.mul) begin
         prod_ff <= PROD_W'(step_ff * $signed({1'b0, el_ff}));
      end
   end

   assign status.is_tick   = kind_ff == KIND_TICK;
   assign status.fade_zero = fade_ff == '0;
   assign status.active    = active;
   assign status.div_last  = cnt_ff == CNT_W'(LEVEL_W - 1);

   assign level_out = level_ff[LEVEL_W-1 -: PORT_W];
   assign applied   = applied_ff;
   assign ramping   = active;

endmodule

// ===== design/lvfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// lvfr_ctrl
// Sequencer: accept a word, route it, run divide or multiply when the word
// needs one, then commit into the result register.
// ----------------------------------------------------------------------------
module lvfr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  lvfr_pkg::status_type  status,
   output lvfr_pkg::cmd_type     cmd
);
   import lvfr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // every accepted word passes the routing state first
               cmd.capture = 1'b1;
               state_in    = ST_MUL;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_COMMIT;
            end
         end
         ST_MUL: begin
            // route the captured word: commit for an immediate set, divide for a fading set, multiply for a tick
            if (!status.is_tick) begin
               state_in = status.fade_zero ? ST_COMMIT : ST_DIV;
            end else begin
               cmd.mul  = 1'b1;
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/linear_volume_fade_ramp.sv =====
// An accepted tick or immediate set passes the routing state and then commits;
// a fading set first runs 28 restoring-divide steps, one per cycle, in the
// step divider. One word is in work at a time, so the input takes no new word
// until the current one commits; the result register frees the input side while a result waits.
// Synchronous active-high reset clears level, goal and step to zero (no fade in progress)
// and drops rsp_valid.
// ----------------------------------------------------------------------------
// linear_volume_fade_ramp
// Linear volume fade generator: set commands load a target and fade time,
// tick words advance the level by step * elapsed ms with clamp at the goal.
// ----------------------------------------------------------------------------
module linear_volume_fade_ramp (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_kind,
   input  logic [lvfr_pkg::PORT_W-1:0] req_target_level,
   input  logic [lvfr_pkg::MS_W-1:0]   req_fade_ms,
   input  logic [lvfr_pkg::MS_W-1:0]   req_elapsed_ms,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [lvfr_pkg::PORT_W-1:0] rsp_level_out,
   output logic                        rsp_applied,
   output logic                        rsp_ramping
);
   import lvfr_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Controller: accept one word, route it, then either
   //  - commit at once (immediate set),
   //  - iterate the divider for the per-ms step (fading set),
   //  - register step * elapsed and then add/clamp (tick).
   // Commit waits until the result register is free, so the response
   // fields, taken straight from the level/goal/step registers, hold
   // while the consumer stalls.
   lvfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: level/goal in Q4.24, signed step in internal LSBs per ms.
   lvfr_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_kind         (req_kind),
      .req_target_level (req_target_level),
      .req_fade_ms      (req_fade_ms),
      .req_elapsed_ms   (req_elapsed_ms),
      .level_out        (rsp_level_out),
      .applied          (rsp_applied),
      .ramping          (rsp_ramping)
   );

endmodule

// ===== design/lvfr_checker.sv =====
// ----------------------------------------------------------------------------
// lvfr_checker
// Port-level checks for the fade generator, bound to the top level.
// ----------------------------------------------------------------------------
module lvfr_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic                        req_kind,
   input  logic [lvfr_pkg::PORT_W-1:0] req_target_level,
   input  logic [lvfr_pkg::MS_W-1:0]   req_fade_ms,
   input  logic [lvfr_pkg::MS_W-1:0]   req_elapsed_ms,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [lvfr_pkg::PORT_W-1:0] rsp_level_out,
   input  logic                        rsp_applied,
   input  logic                        rsp_ramping
);

   // no word survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // one word in work at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted a second word while busy");

   // a new result only comes out of the commit step, never from idle
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a word in work");

   // held result keeps its fields
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_level_out)
         && $stable(rsp_applied) && $stable(rsp_ramping)))
      else $error("stalled result changed");

endmodule

bind linear_volume_fade_ramp lvfr_checker u_lvfr_checker (.*);
